FILE: rtl/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search core.
// Request/response payloads, controller-datapath command/status structs.
// No dependencies.
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;

    // Request modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [WORD_W-1:0]  entry_value;
        logic signed [WORD_W-1:0]  search_key;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // start a search: latch key, reset bounds
        logic write;      // store the request's entry
        logic probe;      // capture the probe index; table read in flight
        logic step;       // narrow bounds after a failed compare
        logic emit_hit;   // load a found response
        logic emit_miss;  // load a miss response
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_range;   // low <= high
        logic hit;        // probed word equals key
    } t_sts;

endpackage

FILE: rtl/stbs_ctrl.sv
// Search sequencer for the sorted-table binary search core.
// Drives datapath commands and the response strobe. Depends on stbs_pkg.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_mode,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_SEARCH) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CHECK;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.in_range) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    o_cmd.emit_miss = 1'b1;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.emit_hit = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: rtl/stbs_dp.sv
// Datapath for the sorted-table binary search core: table memory, count
// register, search bounds, compare and response register. Depends on stbs_pkg.
module stbs_dp
    import stbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  t_req               i_req,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output t_rsp               o_rsp
);

    logic [WORD_W-1:0]        mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]       r_entry_count;
    logic signed [WORD_W-1:0] r_key;
    logic [CNT_W-1:0]         r_lo;      // inclusive low bound
    logic [CNT_W-1:0]         r_hi_x;    // exclusive high bound (high + 1)
    logic [ADDR_W-1:0]        r_mid;
    logic signed [WORD_W-1:0] r_rdata;
    t_rsp                     r_rsp;

    logic [CNT_W-1:0]         count_sat;
    logic [CNT_W-1:0]         span;
    logic [CNT_W-1:0]         mid_full;
    logic [ADDR_W-1:0]        mid;
    logic                     wr_ok;

    always_comb begin
        if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            count_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            count_sat = CNT_W'(r_entry_count);
        end
    end

    // mid = low + floor((high - low) / 2), valid only while low < hi_x
    assign span     = r_hi_x - r_lo - CNT_W'(1);
    assign mid_full = r_lo + (span >> 1);
    assign mid      = ADDR_W'(mid_full);

    assign wr_ok = (32'(i_req.entry_index) < 32'(TABLE_DEPTH));

    assign o_sts.in_range = (r_lo < r_hi_x);
    assign o_sts.hit      = (r_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // Table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            mem[ADDR_W'(i_req.entry_index)] <= i_req.entry_value;
        end
    end

    // Table read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[mid];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_req.search_key;
            r_lo   <= '0;
            r_hi_x <= count_sat;
        end else if (i_cmd.step) begin
            if (r_rdata < r_key) begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                r_hi_x <= CNT_W'(r_mid);
            end
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.emit_hit) begin
            r_rsp.found    <= 1'b1;
            r_rsp.position <= INDEX_W'(r_mid);
        end else if (i_cmd.emit_miss) begin
            r_rsp.found    <= 1'b0;
            r_rsp.position <= '0;
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/sorted_table_binary_search_core.sv
// Top level of the sorted-table binary search core.
// Instantiates stbs_ctrl and stbs_dp; depends on stbs_pkg.
//
// A request is taken on a clock edge with start high and busy low. A write
// request (mode 0) stores entry_value at entry_index, gives no response and
// leaves busy low; indexes at or above the table depth are dropped. A search
// request (mode 1) looks for search_key in entries 0 to entry_count-1 (count
// saturates at the table depth) by binary search and gives exactly one
// response, shown on o_rsp for one cycle with o_valid high. The receiver
// cannot stall: sample o_rsp when o_valid is high. Each probe takes a check
// state (bounds tested, probe index and registered table read taken) and
// then a compare state; a hit ends in the compare state, a miss in a check
// state that finds the bounds empty. A search makes at most
// ceil(log2(count+1)) probes. busy drops on the edge the response is loaded,
// so the next request can be taken while the response is showing. The table
// is not cleared by reset; searches must only touch entries written before.
// entry_count is written through i_cfg_we/i_cfg_wdata; the user must write
// it only while idle, and the core does not enforce this.
module sorted_table_binary_search_core
    import stbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    input  logic               start,
    input  t_req               i_req,
    output logic               busy,
    output logic               o_valid,
    output t_rsp               o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: idle -> check bounds -> compare -> ... -> respond
    stbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_req.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Table, bounds, compare and response register
    stbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: rtl/stbs_chk.sv
// Port-level checker for sorted_table_binary_search_core, with its bind.
// Depends on stbs_pkg.
module stbs_chk
    import stbs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input t_req               i_req,
    input logic               busy,
    input logic               o_valid,
    input t_rsp               o_rsp
);

    // A miss always reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.found) |-> (o_rsp.position == '0))
        else $error("miss response with nonzero position");

    // An accepted search request keeps the core busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode == MODE_SEARCH)) |=> busy)
        else $error("search request did not raise busy");

    // A write request completes in its accept cycle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.mode == MODE_WRITE)) |=> !busy)
        else $error("write request raised busy");

    // Responses only come out of a search in progress
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_valid)
        else $error("response strobe without a search in progress");

    // Strobe lasts one cycle per response
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("response strobe held for two cycles");

endmodule

bind sorted_table_binary_search_core stbs_chk u_stbs_chk (.*);

FILE: tb/sv/tb_sorted_table_binary_search_core.sv
// Self-checking testbench for sorted_table_binary_search_core: directed and random
// table writes and key lookups, checked against an in-bench binary search predictor.
// Depends on stbs_pkg and the core RTL.
module tb_sorted_table_binary_search_core;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request, response or reg write
    localparam int WRITE_SETTLE   = 4;     // a pause after the last table write before a register write
    localparam int DRAIN_CYCLES   = 30;    // longer than a full 1024-entry search
    localparam int ITEM_TARGET    = 1700;
    localparam int MAX_REPORTS    = 100;

    localparam logic signed [WORD_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam longint WORD_MIN_L = -64'sh8000_0000;
    localparam longint WORD_MAX_L = 64'sh7FFF_FFFF;

    // DUT ports; every input starts at a known value
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;
    logic               start       = 1'b0;
    t_req               i_req       = '0;
    logic               busy;
    logic               o_valid;
    t_rsp               o_rsp;

    // Stimulus side: pending requests plus the table contents as planned,
    // used to pick keys that hit or just miss.
    t_req                     request_fifo[$];
    logic signed [WORD_W-1:0] staged_tbl [TABLE_DEPTH];
    int                       queued_cnt = 0;
    int                       gap_left   = 0;
    bit                       steady     = 1'b0;  // phase with back-to-back requests

    // Predictor side: its own copy of the table and of entry_count, updated
    // at the edges where the DUT takes a request or a register write.
    logic signed [WORD_W-1:0] mirror_tbl [TABLE_DEPTH];
    logic [COUNT_W-1:0]       mirror_count = '0;
    t_rsp                     expected_rsp[$];

    bit req_taken  = 1'b0;  // request accepted at the last rising edge
    int taken_cnt  = 0;
    int quiet      = 0;
    int mismatches = 0;
    int n_writes   = 0;
    int n_searches = 0;
    int n_hits     = 0;
    int n_cfg      = 0;

    sorted_table_binary_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Binary search over the mirrored table. Probes at lo + (hi-lo)/2 and stops
    // at the first probe equal to the key, so an unsorted table still follows
    // the same probe sequence. Count saturates at the table depth; a count of
    // zero gives an immediate miss.
    function automatic t_rsp predict_lookup(logic signed [WORD_W-1:0] key);
        int   lo;
        int   hi;
        int   mid;
        t_rsp r;
        r  = '0;
        lo = 0;
        hi = (mirror_count > TABLE_DEPTH ? TABLE_DEPTH : int'(mirror_count)) - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (mirror_tbl[mid] == key) begin
                r.found    = 1'b1;
                r.position = mid[INDEX_W-1:0];
                return r;
            end
            if (mirror_tbl[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: responses are checked first, so a response that shows on the
    // same edge a new search is taken is matched to the older expectation.
    // A stray response does not count as progress for the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        bit   moved;
        moved     = 1'b0;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_rsp.size() == 0) begin
                    flag_mismatch($sformatf("response with no search pending: found=%0b pos=%0d",
                                            o_rsp.found, o_rsp.position));
                end else begin
                    moved = 1'b1;
                    want  = expected_rsp.pop_front();
                    if (o_rsp.found !== want.found)
                        flag_mismatch($sformatf("found: got %b, want %b",
                                                o_rsp.found, want.found));
                    if (o_rsp.position !== want.position)
                        flag_mismatch($sformatf("position: got %0d, want %0d",
                                                o_rsp.position, want.position));
                    if (want.found)
                        n_hits++;
                end
            end
            if (i_cfg_we) begin
                moved        = 1'b1;
                mirror_count = i_cfg_wdata;
            end
            if (start && !busy) begin
                moved     = 1'b1;
                req_taken = 1'b1;
                taken_cnt++;
                if (i_req.mode == MODE_WRITE) begin
                    mirror_tbl[i_req.entry_index] = i_req.entry_value;
                    n_writes++;
                end else begin
                    expected_rsp.push_back(predict_lookup(i_req.search_key));
                    n_searches++;
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles, %0d responses outstanding",
                         quiet, expected_rsp.size());
                $display("sorted_table_binary_search_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: holds a request until it is taken, then idles for the gap
    // drawn with it before presenting the next one.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || req_taken)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (request_fifo.size() != 0) begin
                i_req    <= request_fifo.pop_front();
                start    <= 1'b1;
                gap_left <= steady ? 0 : pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request builders; unused fields carry random bits.
    // ------------------------------------------------------------------
    task automatic queue_write(int idx, logic signed [WORD_W-1:0] value);
        t_req r;
        r.mode        = MODE_WRITE;
        r.entry_index = idx[INDEX_W-1:0];
        r.entry_value = value;
        r.search_key  = $urandom;
        staged_tbl[idx] = value;
        request_fifo.push_back(r);
        queued_cnt++;
    endtask

    task automatic queue_search(logic signed [WORD_W-1:0] key);
        t_req r;
        r.mode        = MODE_SEARCH;
        r.entry_index = INDEX_W'($urandom);
        r.entry_value = $urandom;
        r.search_key  = key;
        request_fifo.push_back(r);
        queued_cnt++;
    endtask

    // All requests taken, no response owed, and the last write has settled.
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (WRITE_SETTLE) @(negedge i_clk);
    endtask

    task automatic set_entry_count(int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cfg++;
    endtask

    // Ascending contents for entries 0..n-1 (n > 0): dense runs with duplicates,
    // runs around zero, spread over the whole signed range, or steps from a random start.
    task automatic fill_sorted(int n);
        longint v;
        longint stepmax;
        case ($urandom_range(0, 3))
            0: begin
                v       = WORD_MIN_L;
                stepmax = 3;
            end
            1: begin
                v       = -longint'($urandom_range(0, 50));
                stepmax = 2;
            end
            2: begin
                v       = WORD_MIN_L + $urandom_range(0, 1000);
                stepmax = 64'hFFFF_FFFF / n;
            end
            default: begin
                v       = longint'($signed($urandom));
                stepmax = 1000;
            end
        endcase
        for (int i = 0; i < n; i++) begin
            if (v > WORD_MAX_L)
                v = WORD_MAX_L;
            queue_write(i, v[WORD_W-1:0]);
            v += longint'($urandom) % (stepmax + 1);
        end
    endtask

    // Keys: table values (hits), neighbors of table values (near misses),
    // extremes, and raw random words.
    function automatic logic signed [WORD_W-1:0] pick_key(int n);
        int r;
        r = $urandom_range(0, 99);
        if (n == 0 || r < 15)
            return $urandom;
        else if (r < 60)
            return staged_tbl[$urandom_range(0, n - 1)];
        else if (r < 85)
            return staged_tbl[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // One setting of entry_count: optional sorted refill, then lookups with
    // the odd stray write mixed in (which may leave the table unsorted).
    task automatic random_phase(int count, bit refill);
        int n;
        int lookups;
        n = count > TABLE_DEPTH ? TABLE_DEPTH : count;
        set_entry_count(count);
        steady = ($urandom_range(0, 3) == 0);
        if (refill && n > 0)
            fill_sorted(n);
        lookups = $urandom_range(3, 24);
        for (int i = 0; i < lookups; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            queue_search(pick_key(n));
        end
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 15)
            return 1;
        else if (r < 25)
            return 2;
        else if (r < 80)
            return $urandom_range(3, 32);
        return $urandom_range(33, 160);
    endfunction

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // entry_count is zero out of reset: every lookup misses
        queue_search(0);
        queue_search(KEY_MIN);
        queue_search(KEY_MAX);
        queue_write(0, KEY_MIN);
        queue_write(1, -1000);
        queue_write(2, -1);
        queue_write(3, 0);
        queue_write(4, 0);
        queue_write(5, 5);
        queue_write(6, 70000);
        queue_write(7, KEY_MAX);

        // eight sorted entries: both ends, a duplicate, and misses in between
        set_entry_count(8);
        queue_search(KEY_MIN);
        queue_search(KEY_MAX);
        queue_search(0);
        queue_search(-1);
        queue_search(70000);
        queue_search(KEY_MIN + 1);
        queue_search(6);
        queue_search(KEY_MAX - 1);
        queue_search(5);
        // break the ordering: a present key is now missed, the new max is hit first
        queue_write(3, KEY_MAX);
        queue_search(0);
        queue_search(KEY_MAX);

        while (queued_cnt < 450)
            random_phase(pick_count(), 1'b1);

        // full table, then counts at, beyond and just below the depth
        random_phase(TABLE_DEPTH, 1'b1);
        random_phase(2047, 1'b0);
        random_phase(TABLE_DEPTH + 1, 1'b0);
        random_phase(TABLE_DEPTH - 1, 1'b0);

        while (queued_cnt < ITEM_TARGET)
            random_phase(pick_count(), 1'b1);
        random_phase(0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d table writes and %0d lookups (%0d hits, %0d misses)",
                 n_writes, n_searches, n_hits, n_searches - n_hits);
        $display("over %0d entry_count settings, with %0d mismatches", n_cfg, mismatches);
        if (mismatches == 0)
            $display("sorted_table_binary_search_core regression: pass");
        else
            $display("sorted_table_binary_search_core regression: fail");
        $finish;
    end

endmodule
